// ===== rtl/lru_file_slot_cache_with_header_check_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the file slot cache; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_FILE_SLOT_CACHE_WITH_HEADER_CHECK_ASSERT_SVH
`define LRU_FILE_SLOT_CACHE_WITH_HEADER_CHECK_ASSERT_SVH

`ifndef SYNTHESIS
`define LFSC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define LFSC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define LFSC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define LFSC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// ===== rtl/lfsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfsc_pkg
// Types, register codes, status codes and reset values of the file slot cache.
// ----------------------------------------------------------------------------
package lfsc_pkg;

	localparam int SLOTS_DEF = 8;
	localparam logic [31:0] HDR_BYTES = 32'd8;

	localparam int IN_W  = 152;
	localparam int OUT_W = 64;

	localparam logic [31:0] MAGIC_MAIN_RST  = 32'h24E9_2764;
	localparam logic [31:0] MAGIC_TEST_RST  = 32'hFA1A_F9BF;
	localparam logic [31:0] MAGIC_LOCAL_RST = 32'hAAE8_3F5F;
	localparam logic [31:0] MAX_BLOCK_RST   = 32'd2000000;

	localparam logic [1:0] REG_MAGIC_MAIN  = 2'd0;
	localparam logic [1:0] REG_MAGIC_TEST  = 2'd1;
	localparam logic [1:0] REG_MAGIC_LOCAL = 2'd2;
	localparam logic [1:0] REG_MAX_BLOCK   = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_REQ   = 3'd1;
	localparam logic [2:0] ST_UNAVAIL   = 3'd2;
	localparam logic [2:0] ST_BEYOND    = 3'd3;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd4;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd5;
	localparam logic [2:0] ST_OVERRUN   = 3'd6;

	typedef struct packed {
		logic [31:0] magic_main;
		logic [31:0] magic_test;
		logic [31:0] magic_local;
		logic [31:0] max_block_size;
	} cfg_t;

	typedef struct packed {
		logic signed [17:0] file_number;
		logic [31:0]        data_pos;
		logic [31:0]        file_bytes;
		logic [31:0]        header_magic;
		logic [31:0]        header_size;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        hit;
		logic [2:0]  slot_index;
		logic        evicted_valid;
		logic [16:0] evicted_file;
		logic [31:0] payload_length;
	} res_t;

	typedef struct packed {
		logic [16:0] file;
		logic [31:0] size;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic en;
		logic set_valid;
		logic clr_valid;
	} wr_ctl_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

endpackage

// ===== rtl/lfsc_cmp.sv =====
// ----------------------------------------------------------------------------
// lfsc_cmp
// Shared 33-bit magnitude and equality comparator.
// ----------------------------------------------------------------------------
module lfsc_cmp (
	input  logic [32:0]     a,
	input  logic [32:0]     b,
	output lfsc_pkg::cmp_t  res
);

	always_comb begin
		res.lt = (a < b);
		res.eq = (a == b);
	end

endmodule

// ===== rtl/lfsc_store.sv =====
// ----------------------------------------------------------------------------
// lfsc_store
// Slot table: file, size and stamp memory with registered read, and the
// valid bits of all slots.
// ----------------------------------------------------------------------------
module lfsc_store #(
	parameter int SLOTS = lfsc_pkg::SLOTS_DEF,
	parameter int SLOT_W = $clog2(SLOTS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [SLOT_W-1:0]       rd_addr,
	output lfsc_pkg::entry_t        rd_data,
	input  logic [SLOT_W-1:0]       wr_addr,
	input  lfsc_pkg::wr_ctl_t       wr_ctl,
	input  lfsc_pkg::entry_t        wr_entry,
	output logic [SLOTS-1:0]        valid
);

	lfsc_pkg::entry_t mem [SLOTS];
	lfsc_pkg::entry_t rd_q;
	logic [SLOTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_ctl.en) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ctl.set_valid) begin
			valid_q[wr_addr] <= 1'b1;
		end else if (wr_ctl.clr_valid) begin
			valid_q[wr_addr] <= 1'b0;
		end
	end

	assign rd_data = rd_q;
	assign valid   = valid_q;

endmodule

// ===== rtl/lfsc_seq.sv =====
// ----------------------------------------------------------------------------
// lfsc_seq
// Request sequencer: slot scan for hit, empty slot and oldest stamp, slot
// update, then the header checks, with stamps and headers on one comparator.
// ----------------------------------------------------------------------------
`include "lru_file_slot_cache_with_header_check_assert.svh"

module lfsc_seq #(
	parameter int SLOTS = lfsc_pkg::SLOTS_DEF,
	parameter int SLOT_W = $clog2(SLOTS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  lfsc_pkg::req_t          req,
	input  lfsc_pkg::cfg_t          cfg,
	input  logic                    out_free,
	output logic                    res_load,
	output lfsc_pkg::res_t          res,
	output logic [SLOT_W-1:0]       rd_addr,
	input  lfsc_pkg::entry_t        rd_data,
	input  logic [SLOTS-1:0]        valid,
	output logic [SLOT_W-1:0]       wr_addr,
	output lfsc_pkg::wr_ctl_t       wr_ctl,
	output lfsc_pkg::entry_t        wr_entry
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_DECIDE = 4'd2;
	localparam logic [3:0] S_POS    = 4'd3;
	localparam logic [3:0] S_M0     = 4'd4;
	localparam logic [3:0] S_M1     = 4'd5;
	localparam logic [3:0] S_M2     = 4'd6;
	localparam logic [3:0] S_BZ     = 4'd7;
	localparam logic [3:0] S_BMAX   = 4'd8;
	localparam logic [3:0] S_OVR    = 4'd9;
	localparam logic [3:0] S_REPLY  = 4'd10;

	localparam logic [SLOT_W:0]   SCAN_END = (SLOT_W + 1)'(SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

	logic [3:0]        state_q;
	logic [31:0]       clock_q;
	logic [SLOT_W:0]   rd_idx_q;
	logic              cmp_vld_s1;
	logic [SLOT_W-1:0] cmp_idx_s1;
	logic              hit_q;
	logic              any_empty_q;
	logic [2:0]        status_q;
	logic              ev_valid_q;

	logic [16:0]       file_q;
	logic [31:0]       pos_q;
	logic [31:0]       fsize_q;
	logic [31:0]       magic_q;
	logic [31:0]       bsize_q;
	logic [32:0]       sum_q;
	logic [SLOT_W-1:0] hit_idx_q;
	logic [31:0]       hit_size_q;
	logic [SLOT_W-1:0] empty_idx_q;
	logic [SLOT_W-1:0] min_idx_q;
	logic [31:0]       min_stamp_q;
	logic [16:0]       min_file_q;
	logic [31:0]       held_q;
	logic [SLOT_W-1:0] slot_q;
	logic [16:0]       ev_file_q;

	logic [32:0]       op_a;
	logic [32:0]       op_b;
	lfsc_pkg::cmp_t    cmp;
	logic              in_fire;
	logic              bad_req;
	logic [31:0]       clock_nx;
	logic [SLOT_W-1:0] victim;
	logic              scan_last;
	logic              slot_vld;
	logic [SLOT_W+2:0] slot_ext;

	lfsc_cmp u_cmp (
		.a   (op_a),
		.b   (op_b),
		.res (cmp)
	);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_IDLE: begin
				op_a = {1'b0, req.data_pos};
				op_b = {1'b0, lfsc_pkg::HDR_BYTES};
			end
			S_SCAN: begin
				op_a = {1'b0, rd_data.stamp};
				op_b = {1'b0, min_stamp_q};
			end
			S_POS: begin
				op_a = {1'b0, held_q};
				op_b = {1'b0, pos_q};
			end
			S_M0: begin
				op_a = {1'b0, magic_q};
				op_b = {1'b0, cfg.magic_main};
			end
			S_M1: begin
				op_a = {1'b0, magic_q};
				op_b = {1'b0, cfg.magic_test};
			end
			S_M2: begin
				op_a = {1'b0, magic_q};
				op_b = {1'b0, cfg.magic_local};
			end
			S_BZ: begin
				op_a = {1'b0, bsize_q};
				op_b = '0;
			end
			S_BMAX: begin
				op_a = {1'b0, cfg.max_block_size};
				op_b = {1'b0, bsize_q};
			end
			S_OVR: begin
				op_a = {1'b0, held_q};
				op_b = sum_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign bad_req   = req.file_number[17] || cmp.lt;
	assign clock_nx  = clock_q + 32'd1;
	assign victim    = any_empty_q ? empty_idx_q : min_idx_q;
	assign scan_last = cmp_vld_s1 && (cmp_idx_s1 == SLOT_LAST);
	assign slot_vld  = valid[cmp_idx_s1];
	assign rd_addr   = rd_idx_q[SLOT_W-1:0];
	assign res_load  = (state_q == S_REPLY) && out_free;

	always_comb begin
		wr_ctl   = '0;
		wr_addr  = hit_q ? hit_idx_q : victim;
		wr_entry.file  = file_q;
		wr_entry.size  = hit_q ? hit_size_q : fsize_q;
		wr_entry.stamp = clock_nx;
		if (state_q == S_DECIDE) begin
			if (hit_q) begin
				wr_ctl.en = 1'b1;
			end else if (fsize_q == 32'd0) begin
				wr_ctl.clr_valid = 1'b1;
			end else begin
				wr_ctl.en        = 1'b1;
				wr_ctl.set_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clock_q     <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			any_empty_q <= 1'b0;
			status_q    <= lfsc_pkg::ST_OK;
			ev_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						rd_idx_q    <= '0;
						cmp_vld_s1  <= 1'b0;
						hit_q       <= 1'b0;
						any_empty_q <= 1'b0;
						ev_valid_q  <= 1'b0;
						if (bad_req) begin
							status_q <= lfsc_pkg::ST_BAD_REQ;
							state_q  <= S_REPLY;
						end else begin
							status_q <= lfsc_pkg::ST_OK;
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_idx_q != SCAN_END) begin
						rd_idx_q <= rd_idx_q + (SLOT_W + 1)'(1);
					end
					cmp_vld_s1 <= (rd_idx_q != SCAN_END);
					if (cmp_vld_s1) begin
						if (slot_vld && (rd_data.file == file_q) && !hit_q) begin
							hit_q <= 1'b1;
						end
						if (!slot_vld) begin
							any_empty_q <= 1'b1;
						end
					end
					if (scan_last) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (hit_q) begin
						clock_q <= clock_nx;
						state_q <= S_POS;
					end else begin
						ev_valid_q <= !any_empty_q;
						if (fsize_q == 32'd0) begin
							status_q <= lfsc_pkg::ST_UNAVAIL;
							state_q  <= S_REPLY;
						end else begin
							clock_q <= clock_nx;
							state_q <= S_POS;
						end
					end
				end
				S_POS: begin
					if (cmp.lt) begin
						status_q <= lfsc_pkg::ST_BEYOND;
						state_q  <= S_REPLY;
					end else begin
						state_q <= S_M0;
					end
				end
				S_M0: begin
					state_q <= cmp.eq ? S_BZ : S_M1;
				end
				S_M1: begin
					state_q <= cmp.eq ? S_BZ : S_M2;
				end
				S_M2: begin
					if (cmp.eq) begin
						state_q <= S_BZ;
					end else begin
						status_q <= lfsc_pkg::ST_BAD_MAGIC;
						state_q  <= S_REPLY;
					end
				end
				S_BZ: begin
					if (cmp.eq) begin
						status_q <= lfsc_pkg::ST_BAD_SIZE;
						state_q  <= S_REPLY;
					end else begin
						state_q <= S_BMAX;
					end
				end
				S_BMAX: begin
					if (cmp.lt) begin
						status_q <= lfsc_pkg::ST_BAD_SIZE;
						state_q  <= S_REPLY;
					end else begin
						state_q <= S_OVR;
					end
				end
				S_OVR: begin
					status_q <= cmp.lt ? lfsc_pkg::ST_OVERRUN : lfsc_pkg::ST_OK;
					state_q  <= S_REPLY;
				end
				S_REPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q[SLOT_W-1:0];
		if (in_fire) begin
			file_q    <= req.file_number[16:0];
			pos_q     <= req.data_pos;
			fsize_q   <= req.file_bytes;
			magic_q   <= req.header_magic;
			bsize_q   <= req.header_size;
			sum_q     <= {1'b0, req.data_pos} + {1'b0, req.header_size};
			slot_q    <= '0;
			ev_file_q <= '0;
		end
		if ((state_q == S_SCAN) && cmp_vld_s1) begin
			if (slot_vld && (rd_data.file == file_q) && !hit_q) begin
				hit_idx_q  <= cmp_idx_s1;
				hit_size_q <= rd_data.size;
			end
			if (!slot_vld && !any_empty_q) begin
				empty_idx_q <= cmp_idx_s1;
			end
			if ((cmp_idx_s1 == '0) || cmp.lt) begin
				min_idx_q   <= cmp_idx_s1;
				min_stamp_q <= rd_data.stamp;
				min_file_q  <= rd_data.file;
			end
		end
		if (state_q == S_DECIDE) begin
			if (hit_q) begin
				slot_q <= hit_idx_q;
				held_q <= hit_size_q;
			end else begin
				slot_q    <= victim;
				held_q    <= fsize_q;
				ev_file_q <= any_empty_q ? 17'd0 : min_file_q;
			end
		end
	end

	assign slot_ext = {3'b000, slot_q};

	always_comb begin
		res.status         = status_q;
		res.hit            = hit_q;
		res.slot_index     = slot_ext[2:0];
		res.evicted_valid  = ev_valid_q;
		res.evicted_file   = ev_file_q;
		res.payload_length = (status_q == lfsc_pkg::ST_OK) ? bsize_q : 32'd0;
	end

	`LFSC_ASSERT_NEXT(a_fire_starts_work, clk, arst_n, in_fire, (state_q == S_SCAN) || (state_q == S_REPLY), "accepted item did not start work")
	`LFSC_ASSERT_IMP(a_hit_slot_valid, clk, arst_n, (state_q == S_DECIDE) && hit_q, valid[hit_idx_q], "hit slot is not valid")
	`LFSC_ASSERT_IMP(a_hit_status, clk, arst_n, res_load && res.hit, (res.status != lfsc_pkg::ST_BAD_REQ) && (res.status != lfsc_pkg::ST_UNAVAIL), "hit with request or availability error")
	`LFSC_ASSERT_IMP(a_len_only_ok, clk, arst_n, res_load && (res.payload_length != 32'd0), res.status == lfsc_pkg::ST_OK, "payload length without success")

endmodule

// ===== rtl/lru_file_slot_cache_with_header_check.sv =====
// ----------------------------------------------------------------------------
// lru_file_slot_cache_with_header_check
// File slot cache with least recently used replacement and block header check.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel and one result item per request leaves
// on the m_axis channel. The cfg channel writes the three accepted magic words
// and the largest block size; it is always ready, and the user must write it
// only while idle, which the block itself does not enforce. The block takes
// one item at a time. A request with a negative file number or a payload
// position below eight goes from acceptance straight to the reply state. Any
// other request scans the slot table one slot per cycle through the slot
// memory's single read port and updates the chosen slot; a miss on an
// unavailable file replies straight away, otherwise up to seven header checks
// run through one shared comparator. The result is loaded into the output
// register as the sequencer leaves the reply state, and the next item is
// accepted in the cycle after that. The result sits in an output register, so
// a new item is taken while the receiver stalls; a further result waits in the
// sequencer until the output register is free. Reset empties every slot,
// zeroes the use counter and loads the configuration defaults.
// ----------------------------------------------------------------------------
module lru_file_slot_cache_with_header_check #(
	parameter int SLOTS = lfsc_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// file_number, data_pos, file_bytes, header_magic, header_size
	input  logic [lfsc_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// status, hit, slot_index, evicted_valid, evicted_file, payload_length
	output logic [lfsc_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [31:0]                cfg_data
);

	localparam int SLOT_W = $clog2(SLOTS);

	lfsc_pkg::cfg_t    cfg_q;
	lfsc_pkg::req_t    req;
	lfsc_pkg::res_t    res;
	lfsc_pkg::res_t    out_q;
	logic              out_valid_q;
	logic              out_free;
	logic              res_load;
	logic [SLOT_W-1:0] rd_addr;
	lfsc_pkg::entry_t  rd_data;
	logic [SLOTS-1:0]  valid;
	logic [SLOT_W-1:0] wr_addr;
	lfsc_pkg::wr_ctl_t wr_ctl;
	lfsc_pkg::entry_t  wr_entry;

	assign req.file_number  = s_axis_tdata[17:0];
	assign req.data_pos     = s_axis_tdata[49:18];
	assign req.file_bytes   = s_axis_tdata[81:50];
	assign req.header_magic = s_axis_tdata[113:82];
	assign req.header_size  = s_axis_tdata[145:114];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_main     <= lfsc_pkg::MAGIC_MAIN_RST;
			cfg_q.magic_test     <= lfsc_pkg::MAGIC_TEST_RST;
			cfg_q.magic_local    <= lfsc_pkg::MAGIC_LOCAL_RST;
			cfg_q.max_block_size <= lfsc_pkg::MAX_BLOCK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lfsc_pkg::REG_MAGIC_MAIN:  cfg_q.magic_main     <= cfg_data;
				lfsc_pkg::REG_MAGIC_TEST:  cfg_q.magic_test     <= cfg_data;
				lfsc_pkg::REG_MAGIC_LOCAL: cfg_q.magic_local    <= cfg_data;
				lfsc_pkg::REG_MAX_BLOCK:   cfg_q.max_block_size <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	lfsc_store #(
		.SLOTS  (SLOTS),
		.SLOT_W (SLOT_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_addr  (wr_addr),
		.wr_ctl   (wr_ctl),
		.wr_entry (wr_entry),
		.valid    (valid)
	);

	lfsc_seq #(
		.SLOTS  (SLOTS),
		.SLOT_W (SLOT_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.req      (req),
		.cfg      (cfg_q),
		.out_free (out_free),
		.res_load (res_load),
		.res      (res),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.valid    (valid),
		.wr_addr  (wr_addr),
		.wr_ctl   (wr_ctl),
		.wr_entry (wr_entry)
	);

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q.payload_length, out_q.evicted_file,
		out_q.evicted_valid, out_q.slot_index, out_q.hit, out_q.status};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the file slot cache with block header check.
// ----------------------------------------------------------------------------
// Requests are driven on the s_axis channel and a scoreboard class predicts
// each result from its own copy of the slot table, recency stamps and
// registers. Each result item is checked field by field against the oldest
// prediction. A directed opening covers rejected requests, unavailable files,
// evictions and every header failure. Six register settings follow, the
// extremes among them, each with random requests that mostly hit a small pool
// of files. Both channels idle at random, and a watchdog ends a stalled run.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lfsc_pkg::*;

	localparam int SLOT_COUNT  = SLOTS_DEF;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 300;
	localparam int POOL        = 12;

	class lfsc_scoreboard;
		bit [31:0] magic_main;
		bit [31:0] magic_test;
		bit [31:0] magic_local;
		bit [31:0] max_block;
		bit        slot_full[SLOT_COUNT];
		bit [16:0] slot_file[SLOT_COUNT];
		bit [31:0] slot_size[SLOT_COUNT];
		bit [31:0] slot_stamp[SLOT_COUNT];
		bit [31:0] use_clock;
		res_t      pending_results[$];
		int        errors;
		int        requests;
		int        hits;
		int        evictions;
		int        status_seen[8];

		function new();
			magic_main  = MAGIC_MAIN_RST;
			magic_test  = MAGIC_TEST_RST;
			magic_local = MAGIC_LOCAL_RST;
			max_block   = MAX_BLOCK_RST;
			foreach (slot_full[i]) begin
				slot_full[i]  = 1'b0;
				slot_stamp[i] = '0;
			end
			use_clock = '0;
			errors    = 0;
			requests  = 0;
			hits      = 0;
			evictions = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void write_reg(bit [1:0] idx, bit [31:0] value);
			case (idx)
				REG_MAGIC_MAIN:  magic_main  = value;
				REG_MAGIC_TEST:  magic_test  = value;
				REG_MAGIC_LOCAL: magic_local = value;
				REG_MAX_BLOCK:   max_block   = value;
				default: ;
			endcase
		endfunction

		function void note_request(bit [IN_W-1:0] item);
			bit [17:0] fnum;
			bit [31:0] pos;
			bit [31:0] fsize;
			bit [31:0] magic;
			bit [31:0] bsize;
			bit [31:0] held;
			bit        found;
			bit        have_empty;
			int        slot;
			int        i;
			res_t      outcome;

			fnum  = item[17:0];
			pos   = item[49:18];
			fsize = item[81:50];
			magic = item[113:82];
			bsize = item[145:114];
			outcome    = '0;
			found      = 1'b0;
			have_empty = 1'b0;
			slot       = 0;
			requests++;

			if (fnum[17] || pos < HDR_BYTES) begin
				outcome.status = ST_BAD_REQ;
			end else begin
				for (i = 0; i < SLOT_COUNT; i++) begin
					if (!found && slot_full[i] && slot_file[i] == fnum[16:0]) begin
						slot  = i;
						found = 1'b1;
					end
				end
				if (found) begin
					outcome.hit = 1'b1;
				end else begin
					for (i = 0; i < SLOT_COUNT; i++) begin
						if (!have_empty && !slot_full[i]) begin
							slot       = i;
							have_empty = 1'b1;
						end
					end
					if (!have_empty) begin
						slot = 0;
						for (i = 1; i < SLOT_COUNT; i++)
							if (slot_stamp[i] < slot_stamp[slot]) slot = i;
						outcome.evicted_valid = 1'b1;
						outcome.evicted_file  = slot_file[slot];
						slot_full[slot]       = 1'b0;
					end
					if (fsize != 0) begin
						slot_full[slot] = 1'b1;
						slot_file[slot] = fnum[16:0];
						slot_size[slot] = fsize;
					end
				end
				outcome.slot_index = slot[2:0];

				if (!found && fsize == 0) begin
					outcome.status = ST_UNAVAIL;
				end else begin
					use_clock        = use_clock + 1;
					slot_stamp[slot] = use_clock;
					held             = slot_size[slot];
					if (pos > held) begin
						outcome.status = ST_BEYOND;
					end else if (magic != magic_main && magic != magic_test &&
							magic != magic_local) begin
						outcome.status = ST_BAD_MAGIC;
					end else if (bsize == 0 || bsize > max_block) begin
						outcome.status = ST_BAD_SIZE;
					end else if ({1'b0, pos} + {1'b0, bsize} > {1'b0, held}) begin
						outcome.status = ST_OVERRUN;
					end else begin
						outcome.status         = ST_OK;
						outcome.payload_length = bsize;
					end
				end
			end

			hits      += outcome.hit;
			evictions += outcome.evicted_valid;
			status_seen[outcome.status]++;
			pending_results.push_back(outcome);
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(bit [OUT_W-1:0] item);
			res_t want;

			if (pending_results.size() == 0) begin
				$error("result item %h arrived with no request outstanding", item);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", want.status, item[2:0]);
			compare_field("hit", want.hit, item[3]);
			compare_field("slot_index", want.slot_index, item[6:4]);
			compare_field("evicted_valid", want.evicted_valid, item[7]);
			compare_field("evicted_file", want.evicted_file, item[24:8]);
			compare_field("payload_length", want.payload_length, item[56:25]);
		endfunction
	endclass

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index     = REG_MAGIC_MAIN;
	logic [31:0]       cfg_data      = '0;

	lfsc_scoreboard     board;
	logic signed [17:0] pool_file[POOL];
	logic [31:0]        pool_size[POOL];
	bit                 steady_send = 1'b0;
	int                 idle_cycles = 0;
	int                 settings_run = 1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	lru_file_slot_cache_with_header_check #(
		.SLOTS(SLOT_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready) board.note_request(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
			if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
					(m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int pick;

		@(negedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(50, 200)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				m_axis_tready <= 1'b0;
				repeat ((pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40))
					@(negedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int pick;

		if (steady_send) return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_req(input logic signed [17:0] fnum, input logic [31:0] pos,
			input logic [31:0] fsize, input logic [31:0] magic, input logic [31:0] bsize);
		int gap;

		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, bsize, magic, fsize, pos, fnum};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (board.pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic program_regs(input logic [31:0] m0, input logic [31:0] m1,
			input logic [31:0] m2, input logic [31:0] mx);
		logic [31:0] vals[4];
		logic [1:0]  regs[4];
		int          i;

		vals = '{m0, m1, m2, mx};
		regs = '{REG_MAGIC_MAIN, REG_MAGIC_TEST, REG_MAGIC_LOCAL, REG_MAX_BLOCK};
		for (i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic program_setting(input int phase);
		logic [31:0] shared;

		shared = $urandom;
		case (phase)
			1: program_regs(32'h0, 32'hFFFF_FFFF, $urandom, 32'd1);
			2: program_regs($urandom, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			3: program_regs($urandom, $urandom, $urandom, $urandom_range(1, 5000000));
			4: program_regs(MAGIC_MAIN_RST, MAGIC_TEST_RST, MAGIC_LOCAL_RST, MAX_BLOCK_RST);
			default: program_regs(shared, shared, 32'h0, $urandom_range(1, 32'hFFFF_FFFF));
		endcase
		settings_run++;
	endtask

	function automatic logic [31:0] pick_magic();
		case ($urandom_range(0, 2))
			0: return board.magic_main;
			1: return board.magic_test;
			default: return board.magic_local;
		endcase
	endfunction

	task automatic send_random();
		int                 pick;
		int                 k;
		logic [31:0]        raw;
		logic signed [17:0] fnum;
		logic [31:0]        pos;
		logic [31:0]        fsize;
		logic [31:0]        magic;
		logic [31:0]        bsize;
		logic [31:0]        room;
		logic [31:0]        lim;

		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			// Unshaped noise: any file number, including negative ones.
			raw   = $urandom;
			fnum  = raw[17:0];
			pos   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
			fsize = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
			magic = ($urandom_range(0, 1) == 0) ? pick_magic() : $urandom;
			bsize = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4096) : $urandom;
		end else begin
			k     = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, POOL - 1);
			fnum  = pool_file[k];
			fsize = ($urandom_range(0, 99) < 3) ? 32'h0 : pool_size[k];
			pos   = HDR_BYTES + $urandom_range(0, (pool_size[k] - HDR_BYTES) >> 1);
			room  = pool_size[k] - pos;
			lim   = (room < board.max_block) ? room : board.max_block;
			if (lim == 0)
				bsize = 32'd1;
			else if ($urandom_range(0, 3) == 0)
				bsize = lim;
			else
				bsize = $urandom_range(1, lim);
			magic = pick_magic();
			if (pick >= 80) begin
				case ($urandom_range(0, 3))
					0: pos = pool_size[k] + 1 + $urandom_range(0, 3);
					1: magic = $urandom;
					2: bsize = ($urandom_range(0, 1) == 0) ? 32'h0 : board.max_block + 1;
					default: bsize = room + 1;
				endcase
			end
		end
		send_req(fnum, pos, fsize, magic, bsize);
	endtask

	task automatic run_directed();
		send_req(18'sh3FFFF, 32'd100, 32'd1000, MAGIC_MAIN_RST, 32'd10);
		send_req(18'sh20000, 32'd8, 32'd1000, MAGIC_MAIN_RST, 32'd10);
		send_req(18'sd5, 32'd7, 32'd1000, MAGIC_MAIN_RST, 32'd10);
		send_req(18'sd5, 32'd0, 32'd1000, MAGIC_MAIN_RST, 32'd10);
		send_req(18'sd0, 32'd8, 32'd0, MAGIC_MAIN_RST, 32'd10);
		send_req(18'sd0, 32'd8, 32'd1000, MAGIC_MAIN_RST, 32'd100);
		send_req(18'sd0, 32'd1001, 32'd5, MAGIC_MAIN_RST, 32'd1);
		send_req(18'sd99999, 32'd8, 32'hFFFF_FFFF, MAGIC_TEST_RST, MAX_BLOCK_RST);
		send_req(18'sh1FFFF, 32'd8, 32'd5000000, MAGIC_LOCAL_RST, MAX_BLOCK_RST + 1);
		send_req(18'sd1, 32'd8, 32'd1000, MAGIC_LOCAL_RST, 32'd0);
		send_req(18'sd2, 32'd8, 32'd1000, 32'h1234_5678, 32'd10);
		send_req(18'sd3, 32'd50, 32'd100, MAGIC_MAIN_RST, 32'd51);
		send_req(18'sd3, 32'd50, 32'd100, MAGIC_MAIN_RST, 32'd50);
		send_req(18'sd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, MAGIC_TEST_RST, 32'd1);
		send_req(18'sd6, 32'd8, 32'd8, MAGIC_MAIN_RST, 32'd1);
		// The table is full from here on, so misses evict.
		send_req(18'sd7, 32'd8, 32'd4096, MAGIC_MAIN_RST, 32'd4088);
		send_req(18'sd8, 32'd8, 32'd0, MAGIC_MAIN_RST, 32'd1);
		send_req(18'sd9, 32'd8, 32'd4096, MAGIC_LOCAL_RST, 32'd1);
		send_req(18'sd0, 32'd16, 32'd1000, MAGIC_MAIN_RST, 32'd1);
		send_req(18'sd99999, 32'hFFFF_FFF0, 32'hFFFF_FFFF, MAGIC_TEST_RST, 32'h10);
	endtask

	initial begin
		int phase;
		int n;
		int k;

		board = new();
		pool_file[0] = 18'sd0;
		pool_size[0] = 32'd1000;
		pool_file[1] = 18'sd99999;
		pool_size[1] = 32'hFFFF_FFFF;
		for (k = 2; k < POOL; k++) begin
			pool_file[k] = 18'sd100 + 18'(k * 7919);
			pool_size[k] = $urandom_range(64, 32'h40_0000);
		end
		pool_size[POOL - 1] = HDR_BYTES;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				wait_drained();
				program_setting(phase);
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) wait_drained();
				steady_send = (n >= 200 && n < 260);
				send_random();
			end
		end

		wait_drained();
		repeat (30) @(negedge clk);

		$display("Ran %0d requests under %0d register settings: %0d hits, %0d evictions.",
			board.requests, settings_run, board.hits, board.evictions);
		$display("Status mix: ok %0d, bad request %0d, unavailable %0d, beyond %0d, %s %0d, %s %0d, %s %0d.",
			board.status_seen[ST_OK], board.status_seen[ST_BAD_REQ],
			board.status_seen[ST_UNAVAIL], board.status_seen[ST_BEYOND],
			"bad magic", board.status_seen[ST_BAD_MAGIC],
			"bad size", board.status_seen[ST_BAD_SIZE],
			"overrun", board.status_seen[ST_OVERRUN]);
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
